@@ rtl/ustp_pkg.sv @@
package ustp_pkg;

  localparam int MAX_LENGTH_DEFAULT = 255;
  localparam int QUEUE_DEPTH        = 2;
  localparam int BASE_W             = 6;
  localparam int ADDR_W             = 3;

  localparam logic [BASE_W-1:0] DIGIT_NONE  = 6'd63;
  localparam logic [BASE_W-1:0] BASE_AUTO   = 6'd0;
  localparam logic [BASE_W-1:0] BASE_UNARY  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCTAL  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [BASE_W-1:0] BASE_LIMIT  = 6'd36;

  localparam logic [7:0] CASE_FOLD_MASK = 8'hdf;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_CR        = 8'h0d;
  localparam logic [7:0] CHAR_MINUS     = 8'h2d;
  localparam logic [7:0] CHAR_PLUS      = 8'h2b;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z   = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
  localparam logic [7:0] COUNT_MAX      = 8'hff;

  localparam logic REG_NUMBER_BASE = 1'b0;

  typedef struct packed {
    logic [BASE_W-1:0] digit;
    logic              blank;
    logic              minus;
    logic              plus;
    logic              zero;
    logic              hex_x;
    logic              last;
  } char_class_t;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE,
    DS_SEEN,
    DS_OVER
  } digit_status_t;

  function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
    logic [BASE_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = BASE_W'(c - CHAR_ZERO);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = BASE_W'(c - CHAR_UPPER_A) + BASE_DEC;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = BASE_W'(c - CHAR_LOWER_A) + BASE_DEC;
    end
    return d;
  endfunction

endpackage

@@ rtl/ustp_front.sv @@
module ustp_front
  import ustp_pkg::*;
(
  input  logic [7:0]  character,
  input  logic        last_of_string,
  output char_class_t item
);

  always_comb begin
    item.digit = digit_of(character);
    item.blank = (character == CHAR_SPACE) ||
                 (character >= CHAR_TAB && character <= CHAR_CR);
    item.minus = (character == CHAR_MINUS);
    item.plus  = (character == CHAR_PLUS);
    item.zero  = (character == CHAR_ZERO);
    item.hex_x = ((character & CASE_FOLD_MASK) == CHAR_UPPER_X);
    item.last  = last_of_string;
  end

endmodule

@@ rtl/ustp_queue.sv @@
module ustp_queue
  import ustp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  char_class_t wr_data,
  output logic        rd_valid,
  input  logic        rd_ready,
  output char_class_t rd_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  char_class_t      entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             push;
  logic             pop;

  assign wr_ready = (fill != (PTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ustp_back.sv @@
module ustp_back
  import ustp_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [BASE_W-1:0] number_base,
  input  logic              q_valid,
  output logic              q_ready,
  input  char_class_t       q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       value,
  output logic              overflow,
  output logic [7:0]        consumed_count
);

  localparam int POS_W = $clog2(MAX_LENGTH + 1);
  localparam int EXT_W = POS_W + 8;

  phase_t            phase, phase_next;
  logic              neg, neg_next;
  logic [BASE_W-1:0] eff_base, eff_base_next;
  logic [31:0]       acc, acc_next;
  digit_status_t     dstat, dstat_next;
  logic [POS_W-1:0]  byte_pos, byte_pos_next;
  logic [POS_W-1:0]  end_pos, end_pos_next;

  logic [BASE_W-1:0] base_sel;
  logic              try_digit;
  logic              take_direct;
  logic              take;
  logic [37:0]       prod;
  logic              base_bad;
  logic              base_auto;
  logic              base_hex;
  logic              step;

  logic              out_neg;
  logic [31:0]       out_acc;
  digit_status_t     out_dstat;
  logic [POS_W-1:0]  out_end;
  logic [EXT_W-1:0]  end_ext;

  assign base_bad  = (number_base == BASE_UNARY) || (number_base > BASE_LIMIT);
  assign base_auto = (number_base == BASE_AUTO);
  assign base_hex  = (number_base == BASE_HEX);

  // The final byte may only proceed when the result slot is free or being emptied.
  assign step    = q_valid && (!q_item.last || !out_valid || out_ready);
  assign q_ready = step;

  assign prod = 38'(acc) * 38'(base_sel) + 38'(q_item.digit);

  always_comb begin
    phase_next    = phase;
    neg_next      = neg;
    eff_base_next = eff_base;
    acc_next      = acc;
    dstat_next    = dstat;
    byte_pos_next = byte_pos;
    end_pos_next  = end_pos;
    base_sel      = eff_base;
    try_digit     = 1'b0;
    take_direct   = 1'b0;
    take          = 1'b0;

    if (byte_pos >= POS_W'(MAX_LENGTH)) begin
      phase_next = PH_DONE;
    end else begin
      byte_pos_next = byte_pos + 1'b1;
      unique case (phase)
        PH_SPACE, PH_START: begin
          if (phase == PH_SPACE && q_item.blank) begin
            phase_next = PH_SPACE;
          end else if (phase == PH_SPACE && q_item.minus) begin
            neg_next   = 1'b1;
            phase_next = PH_START;
          end else if (phase == PH_SPACE && q_item.plus) begin
            phase_next = PH_START;
          end else if (base_bad) begin
            phase_next = PH_DONE;
          end else if ((base_auto || base_hex) && q_item.zero) begin
            // A leading zero counts as a digit and may open a hex prefix.
            eff_base_next = base_hex ? BASE_HEX : BASE_OCTAL;
            base_sel      = eff_base_next;
            take_direct   = 1'b1;
            phase_next    = PH_ZERO;
          end else begin
            eff_base_next = base_auto ? BASE_DEC : number_base;
            base_sel      = eff_base_next;
            try_digit     = 1'b1;
          end
        end
        PH_ZERO: begin
          if (q_item.hex_x) begin
            eff_base_next = BASE_HEX;
            phase_next    = PH_DIGITS;
          end else begin
            try_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          try_digit = 1'b1;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    if (try_digit) begin
      if (q_item.digit < base_sel) begin
        take       = 1'b1;
        phase_next = PH_DIGITS;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (take || take_direct) begin
      end_pos_next = byte_pos + 1'b1;
      if (dstat == DS_OVER || prod[37:32] != '0) begin
        dstat_next = DS_OVER;
      end else begin
        acc_next   = prod[31:0];
        dstat_next = DS_SEEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SPACE;
      neg      <= 1'b0;
      eff_base <= '0;
      acc      <= '0;
      dstat    <= DS_NONE;
      byte_pos <= '0;
      end_pos  <= '0;
    end else if (step) begin
      if (q_item.last) begin
        phase    <= PH_SPACE;
        neg      <= 1'b0;
        eff_base <= '0;
        acc      <= '0;
        dstat    <= DS_NONE;
        byte_pos <= '0;
        end_pos  <= '0;
      end else begin
        phase    <= phase_next;
        neg      <= neg_next;
        eff_base <= eff_base_next;
        acc      <= acc_next;
        dstat    <= dstat_next;
        byte_pos <= byte_pos_next;
        end_pos  <= end_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && q_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && q_item.last) begin
      out_neg   <= neg_next;
      out_acc   <= acc_next;
      out_dstat <= dstat_next;
      out_end   <= end_pos_next;
    end
  end

  // The result register keeps the raw parse state; sign and saturation are applied here.
  assign end_ext  = EXT_W'(out_end);
  assign overflow = (out_dstat == DS_OVER);
  assign value    = overflow ? '1 : (out_neg ? (32'd0 - out_acc) : out_acc);

  always_comb begin
    if (out_dstat == DS_NONE) begin
      consumed_count = '0;
    end else if (end_ext > EXT_W'(COUNT_MAX)) begin
      consumed_count = COUNT_MAX;
    end else begin
      consumed_count = end_ext[7:0];
    end
  end

endmodule

@@ rtl/unsigned_integer_text_parser_core.sv @@
// Text-to-unsigned-integer parser with strtoul behaviour in the C locale.
// Input channel: one character a request (character, last_of_string) on
// in_valid/in_ready. A result request (value, overflow, consumed_count) on
// out_valid/out_ready follows each character marked last_of_string; other
// characters give no result.
// Throughput is one character a cycle, except while a last character waits for
// a busy result slot; the multiply-accumulate of the back end (accumulator
// times base plus digit) is combinational. The last character, once accepted,
// is written into the classification queue; the parse step then takes it from
// the queue and loads the result register, which drives out_valid.
// The radix is the register at byte address 0 of the APB port: 2 to 36, or 0
// for automatic octal, decimal or hex detection; change it only when idle.
// Reset clears the radix to 0 and the parse state; no clearing pass is needed.
// When out_ready is low the result is held, characters of the next string
// still flow into the parser, and only its last character waits in the queue;
// in_ready falls once the two-entry queue is full.
module unsigned_integer_text_parser_core
  import ustp_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        character,
  input  logic              last_of_string,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       value,
  output logic              overflow,
  output logic [7:0]        consumed_count
);

  logic [BASE_W-1:0] number_base;
  char_class_t       front_item;
  char_class_t       q_item;
  logic              q_valid;
  logic              q_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_NUMBER_BASE) ? 32'(number_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1] == REG_NUMBER_BASE) begin
      number_base <= pwdata[BASE_W-1:0];
    end
  end

  ustp_front u_front (
    .character      (character),
    .last_of_string (last_of_string),
    .item           (front_item)
  );

  ustp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (front_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_item)
  );

  ustp_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .number_base    (number_base),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .overflow       (overflow),
    .consumed_count (consumed_count)
  );

`ifndef SYNTHESIS
  a_overflow_saturates : assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> value == '1)
    else $error("overflow result without saturated value");

  a_no_digit_is_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && consumed_count == 8'd0 |-> value == 32'd0 && !overflow)
    else $error("result without consumed digits is not zero");

  a_count_in_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(consumed_count) <= 32'(MAX_LENGTH))
    else $error("consumed count beyond maximum string length");

  a_last_waits_for_slot : assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready && q_item.last |-> !out_valid || out_ready)
    else $error("last character taken while result slot is occupied");
`endif

endmodule
